FILE: rtl/pdfse_pkg.sv
// Shared types and constants for the PDF literal string escape decoder.
`default_nettype none

package pdfse_pkg;

    // One raw byte of the string body.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    // One decoded result.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_string;
        logic       likely_utf;
    } out_item_t;

    // Up to two results produced by one raw byte, in order.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } dec_res_t;

    // Escape tracking state, one-hot.
    typedef enum logic [3:0] {
        PH_PLAIN = 4'b0001,
        PH_ESC   = 4'b0010,
        PH_DIG1  = 4'b0100,
        PH_DIG2  = 4'b1000
    } phase_t;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Character codes.
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_FF      = 8'h0c;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_DEL     = 8'h7f;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_N = 8'h6e;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

endpackage

`default_nettype wire

FILE: rtl/pdfse_decode.sv
// Escape state machine: decodes one raw byte into up to two results.
`default_nettype none

module pdfse_decode (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire pdfse_pkg::in_item_t item,
    output pdfse_pkg::dec_res_t      res
);
    import pdfse_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] first_digit_reg, first_digit_next;
    logic [7:0] second_digit_reg, second_digit_next;
    logic       saw_reg, saw_next;

    logic [7:0] b;
    logic       last;
    logic       is_dec, b_oct, fd_oct, sd_oct;
    logic       plain_emit;
    phase_t     plain_phase;
    logic       have0, have1;
    logic [7:0] val0, val1;
    logic       hi0, hi1;

    // Next state and result slots for the byte in the input register.
    always_comb
    begin
        b                 = item.in_byte;
        last              = item.in_last;
        is_dec            = b inside {[CH_ZERO:CH_NINE]};
        b_oct             = b inside {[CH_ZERO:CH_SEVEN]};
        fd_oct            = first_digit_reg inside {[CH_ZERO:CH_SEVEN]};
        sd_oct            = second_digit_reg inside {[CH_ZERO:CH_SEVEN]};
        plain_emit        = !((b == CH_BSLASH) && !last);
        plain_phase       = plain_emit ? PH_PLAIN : PH_ESC;
        phase_next        = phase_reg;
        first_digit_next  = first_digit_reg;
        second_digit_next = second_digit_reg;
        have0             = 1'b0;
        have1             = 1'b0;
        val0              = b;
        val1              = b;

        case (phase_reg)
            PH_PLAIN:
            begin
                have0      = plain_emit;
                phase_next = plain_phase;
            end
            PH_ESC:
            begin
                if (is_dec && !last)
                begin
                    first_digit_next = b;
                    phase_next       = PH_DIG1;
                end
                else
                begin
                    phase_next = PH_PLAIN;
                    case (b)
                        CH_LOWER_N: begin have0 = 1'b1; val0 = CH_LF;  end
                        CH_LOWER_R: begin have0 = 1'b1; val0 = CH_CR;  end
                        CH_LOWER_T: begin have0 = 1'b1; val0 = CH_TAB; end
                        CH_LOWER_B: begin have0 = 1'b1; val0 = CH_BS;  end
                        CH_LOWER_F: begin have0 = 1'b1; val0 = CH_FF;  end
                        CH_LPAREN, CH_RPAREN, CH_BSLASH: have0 = 1'b1;
                        default: have0 = 1'b0;
                    endcase
                end
            end
            PH_DIG1:
            begin
                if (is_dec && !last)
                begin
                    second_digit_next = b;
                    phase_next        = PH_DIG2;
                end
                else
                begin
                    // The first digit is dropped; this byte is plain text.
                    have0      = plain_emit;
                    phase_next = plain_phase;
                end
            end
            PH_DIG2:
            begin
                if (is_dec)
                begin
                    phase_next = PH_PLAIN;
                    have0      = fd_oct && sd_oct && b_oct;
                    val0       = {first_digit_reg[1:0], second_digit_reg[2:0], b[2:0]};
                end
                else
                begin
                    // Held second digit goes out, then this byte as plain text.
                    have0      = 1'b1;
                    val0       = second_digit_reg;
                    have1      = plain_emit;
                    phase_next = plain_phase;
                end
            end
            default:
            begin
                phase_next = PH_PLAIN;
            end
        endcase

        hi0      = have0 && ((val0 > CH_DEL) || (val0 == 8'h00));
        hi1      = have1 && ((val1 > CH_DEL) || (val1 == 8'h00));
        saw_next = saw_reg | hi0 | hi1;

        // Assemble the result slots.
        res.first.out_byte       = have0 ? val0 : 8'h00;
        res.first.has_byte       = have0;
        res.first.end_of_string  = 1'b0;
        res.first.likely_utf     = 1'b0;
        res.second.out_byte      = val1;
        res.second.has_byte      = have1;
        res.second.end_of_string = 1'b0;
        res.second.likely_utf    = 1'b0;
        res.count                = have1 ? 2'd2 : (have0 ? 2'd1 : 2'd0);

        // The last byte always closes with a flagged result and clears state.
        if (last)
        begin
            if (have1)
            begin
                res.second.end_of_string = 1'b1;
                res.second.likely_utf    = saw_next;
            end
            else
            begin
                res.first.end_of_string = 1'b1;
                res.first.likely_utf    = saw_next;
                res.count               = 2'd1;
            end
            phase_next        = PH_PLAIN;
            first_digit_next  = 8'h00;
            second_digit_next = 8'h00;
            saw_next          = 1'b0;
        end
    end

    // State registers advance once per decoded byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PLAIN;
            first_digit_reg  <= 8'h00;
            second_digit_reg <= 8'h00;
            saw_reg          <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            first_digit_reg  <= first_digit_next;
            second_digit_reg <= second_digit_next;
            saw_reg          <= saw_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pdfse_queue.sv
// Result queue: takes up to two results per cycle, hands out one per request.
`default_nettype none

module pdfse_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire pdfse_pkg::dec_res_t res,
    output logic                     room,
    output logic                     valid,
    input  wire logic                stall,
    output pdfse_pkg::out_item_t     item
);
    import pdfse_pkg::*;

    out_item_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [1:0]          push_cnt;
    logic                pop;

    // Flow control: a push needs space for two results.
    always_comb
    begin
        push_cnt   = push ? res.count : 2'd0;
        pop        = valid && !stall;
        count_next = count_reg + {{(QCNT_W-2){1'b0}}, push_cnt}
                     - {{(QCNT_W-1){1'b0}}, pop};
    end

    assign room  = count_reg <= QCNT_W'(QDEPTH - 2);
    assign valid = count_reg != '0;
    assign item  = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= res.first;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + QPTR_W'(1)] <= res.second;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pdf_string_escape_decoder.sv
// Path: a byte goes through the input register, then the result queue.
// Throughput: one byte per cycle while the queue has room; the results of a
// byte go out one at a time through the four-entry queue's single-result port.
// Reset: rst_n clears the input valid flag, escape state and queue at once;
// byte_stall is low when reset is released, so the block then takes requests.
`default_nettype none

module pdf_string_escape_decoder (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_stall,
    input  wire pdfse_pkg::in_item_t  byte_item,
    output logic                      dec_valid,
    input  wire logic                 dec_stall,
    output pdfse_pkg::out_item_t      dec_item
);
    import pdfse_pkg::*;

    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      room;
    logic      fire;
    logic      accept;
    dec_res_t  res;

    // Input register advances when the queue can take its results.
    assign fire       = s1_valid_reg && room;
    assign byte_stall = s1_valid_reg && !room;
    assign accept     = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= byte_item;
        end
    end

    // Escape decoding.
    pdfse_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (s1_item_reg),
        .res   (res)
    );

    // Result queue toward the output port.
    pdfse_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .res   (res),
        .room  (room),
        .valid (dec_valid),
        .stall (dec_stall),
        .item  (dec_item)
    );

endmodule

`default_nettype wire

FILE: rtl/pdfse_checker.sv
// Port-level checks for the decoder and the bind that attaches them.
`default_nettype none

module pdfse_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 byte_valid,
    input wire logic                 byte_stall,
    input wire pdfse_pkg::in_item_t  byte_item,
    input wire logic                 dec_valid,
    input wire logic                 dec_stall,
    input wire pdfse_pkg::out_item_t dec_item
);
    import pdfse_pkg::*;

    // A stalled request stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
        else $error("stalled request changed");

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_stall |=> dec_valid && $stable(dec_item))
        else $error("stalled result changed");

    // An empty result is only the end marker, and carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_item.has_byte |->
            dec_item.end_of_string && (dec_item.out_byte == 8'h00))
        else $error("empty result is not a clean end marker");

    // The UTF hint appears only on the end result.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_item.end_of_string |-> !dec_item.likely_utf)
        else $error("likely_utf set before end of string");

    // An end result that itself carries a high or zero byte must set the hint.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_item.end_of_string && dec_item.has_byte &&
        ((dec_item.out_byte > CH_DEL) || (dec_item.out_byte == 8'h00)) |->
            dec_item.likely_utf)
        else $error("likely_utf missing for high or zero end byte");

endmodule

bind pdf_string_escape_decoder pdfse_checker u_pdfse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .dec_valid  (dec_valid),
    .dec_stall  (dec_stall),
    .dec_item   (dec_item)
);

`default_nettype wire

FILE: test/pdf_string_escape_decoder_test.sv
// Self-checking testbench for the PDF literal string escape decoder.
`default_nettype none

module pdf_string_escape_decoder_test;
    import pdfse_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 20;
    localparam int RAND_ITEMS  = 1200;
    localparam logic [7:0] CH_NUL = 8'h00;

    // Idling modes, stepped through as the run goes on.
    localparam int MODE_SLOW_SINK = 0;
    localparam int MODE_SLOW_SRC  = 1;
    localparam int MODE_NO_IDLE   = 2;

    // A queued request; hold_drain makes the driver wait for all results first.
    typedef struct packed {
        in_item_t req;
        logic     hold_drain;
    } pend_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    in_item_t   byte_item = '0;
    logic       dec_valid;
    logic       dec_stall = 1'b0;
    out_item_t  dec_item;

    pend_t      request_q[$];
    out_item_t  decoded_q[$];
    logic [7:0] str_buf[$];

    // Predictor state of the escape decoder.
    phase_t     esc_phase = PH_PLAIN;
    logic [7:0] digit_a = '0;
    logic [7:0] digit_b = '0;
    logic       wide_seen = 1'b0;
    int         produced;

    int         errors = 0;
    int         sent = 0;
    int         total_items = 0;
    int         idle_mode = MODE_SLOW_SINK;
    int         idle_cycles = 0;

    pdf_string_escape_decoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .dec_valid  (dec_valid),
        .dec_stall  (dec_stall),
        .dec_item   (dec_item)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic logic is_decimal(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_SEVEN;
    endfunction

    // Record one decoded byte and track whether it hints at a non-ASCII string.
    function automatic void push_byte(input logic [7:0] b);
        out_item_t r;
        r = '0;
        r.out_byte = b;
        r.has_byte = 1'b1;
        decoded_q.push_back(r);
        produced++;
        if (b > CH_DEL || b == CH_NUL)
            wide_seen = 1'b1;
    endfunction

    // A byte seen outside any escape.
    function automatic void take_plain(input logic [7:0] b, input logic last);
        if (b == CH_BSLASH && !last) begin
            esc_phase = PH_ESC;
        end
        else begin
            esc_phase = PH_PLAIN;
            push_byte(b);
        end
    endfunction

    // The byte right after a backslash, when it does not start a digit run.
    function automatic void take_escaped(input logic [7:0] b);
        esc_phase = PH_PLAIN;
        case (b)
            CH_LOWER_N: push_byte(CH_LF);
            CH_LOWER_R: push_byte(CH_CR);
            CH_LOWER_T: push_byte(CH_TAB);
            CH_LOWER_B: push_byte(CH_BS);
            CH_LOWER_F: push_byte(CH_FF);
            CH_LPAREN:  push_byte(CH_LPAREN);
            CH_RPAREN:  push_byte(CH_RPAREN);
            CH_BSLASH:  push_byte(CH_BSLASH);
            default: ;
        endcase
    endfunction

    // Work out the results of one accepted request and queue them.
    function automatic void decode_request(input in_item_t it);
        logic [7:0] b;
        logic       last;
        out_item_t  tail;
        b = it.in_byte;
        last = it.in_last;
        produced = 0;
        case (esc_phase)
            PH_ESC:
                if (is_decimal(b) && !last) begin
                    digit_a = b;
                    esc_phase = PH_DIG1;
                end
                else begin
                    take_escaped(b);
                end
            PH_DIG1:
                if (is_decimal(b) && !last) begin
                    digit_b = b;
                    esc_phase = PH_DIG2;
                end
                else begin
                    // The lone first digit is dropped.
                    take_plain(b, last);
                end
            PH_DIG2:
                if (is_decimal(b)) begin
                    esc_phase = PH_PLAIN;
                    if (is_octal(digit_a) && is_octal(digit_b) && is_octal(b))
                        push_byte({digit_a[1:0], digit_b[2:0], b[2:0]});
                end
                else begin
                    push_byte(digit_b);
                    take_plain(b, last);
                end
            default:
                take_plain(b, last);
        endcase

        // The last byte closes the string, with an empty marker if needed.
        if (last) begin
            if (produced == 0)
                decoded_q.push_back('0);
            tail = decoded_q.pop_back();
            tail.end_of_string = 1'b1;
            tail.likely_utf = wide_seen;
            decoded_q.push_back(tail);
            esc_phase = PH_PLAIN;
            digit_a = '0;
            digit_b = '0;
            wide_seen = 1'b0;
        end
    endfunction

    function automatic void add_item(input logic [7:0] b, input logic last,
                                     input logic drain);
        pend_t e;
        e.req.in_byte = b;
        e.req.in_last = last;
        e.hold_drain = drain;
        request_q.push_back(e);
    endfunction

    // Queue a whole string given as right-aligned hex bytes, first byte leftmost.
    function automatic void add_string(input logic [159:0] bytes, input int n,
                                       input logic drain);
        for (int i = 0; i < n; i++)
            add_item(bytes[8*(n-1-i) +: 8], i == n - 1, drain && i == 0);
    endfunction

    // Append one random fragment of string body to str_buf.
    function automatic void add_fragment();
        logic [7:0] esc_chars[9];
        int         kind;
        int         ndig;
        esc_chars = '{CH_LOWER_N, CH_LOWER_R, CH_LOWER_T, CH_LOWER_B, CH_LOWER_F,
                      CH_LPAREN, CH_RPAREN, CH_BSLASH, 8'($urandom_range(255))};
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2: str_buf.push_back(8'($urandom_range(255)));
            3, 4: begin
                str_buf.push_back(CH_BSLASH);
                str_buf.push_back(esc_chars[$urandom_range(8)]);
            end
            5, 6: begin
                str_buf.push_back(CH_BSLASH);
                for (int i = 0; i < 3; i++)
                    str_buf.push_back(CH_ZERO + 8'($urandom_range(7)));
            end
            7: begin
                str_buf.push_back(CH_BSLASH);
                for (int i = 0; i < 3; i++)
                    str_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
            8: begin
                // Digit run cut short before three digits.
                ndig = $urandom_range(1, 2);
                str_buf.push_back(CH_BSLASH);
                for (int i = 0; i < ndig; i++)
                    str_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
            default:
                case ($urandom_range(2))
                    0: str_buf.push_back(CH_BSLASH);
                    1: str_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
                    default: str_buf.push_back(8'($urandom_range(255)));
                endcase
        endcase
    endfunction

    // Build random strings; most are whole fragments, some are cut mid-escape.
    function automatic void add_random_strings();
        int target;
        int count;
        int len;
        count = 0;
        while (count < RAND_ITEMS) begin
            str_buf.delete();
            target = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
            while (str_buf.size() < target)
                add_fragment();
            len = ($urandom_range(3) == 0) ? target : str_buf.size();
            for (int i = 0; i < len; i++) begin
                add_item(str_buf[i], i == len - 1,
                         i == 0 && (count == 0 || (count >= RAND_ITEMS / 2 &&
                                                   count < RAND_ITEMS / 2 + len)));
            end
            count += len;
        end
    endfunction

    // Sender: presents queued requests, idling at random between them.
    always @(posedge clk or negedge rst_n) begin : drive_proc
        pend_t nxt;
        logic  accepted;
        int    idle_pct;
        int    mode;
        if (!rst_n) begin
            byte_valid <= 1'b0;
            byte_item <= '0;
        end
        else begin
            accepted = byte_valid && !byte_stall;
            if (accepted) begin
                decode_request(byte_item);
                sent++;
            end
            mode = (total_items > 0) ? (sent * 3) / total_items : MODE_NO_IDLE;
            if (mode > MODE_NO_IDLE)
                mode = MODE_NO_IDLE;
            idle_mode <= mode;
            idle_pct = (mode == MODE_SLOW_SINK) ? 14 : (mode == MODE_SLOW_SRC) ? 86 : 0;
            if (!byte_valid || accepted) begin
                if (request_q.size() > 0 &&
                    !(request_q[0].hold_drain && decoded_q.size() > 0) &&
                    $urandom_range(99) >= idle_pct) begin
                    nxt = request_q.pop_front();
                    byte_valid <= 1'b1;
                    byte_item <= nxt.req;
                end
                else begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result against the oldest expectation.
    always @(posedge clk or negedge rst_n) begin : check_proc
        out_item_t want;
        int        stall_pct;
        if (!rst_n) begin
            dec_stall <= 1'b0;
        end
        else begin
            if (dec_valid && !dec_stall) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", dec_item));
                end
                else begin
                    want = decoded_q.pop_front();
                    if (dec_item.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  dec_item.out_byte, want.out_byte));
                    if (dec_item.has_byte !== want.has_byte)
                        report_mismatch($sformatf("has_byte %b, expected %b",
                                                  dec_item.has_byte, want.has_byte));
                    if (dec_item.end_of_string !== want.end_of_string)
                        report_mismatch($sformatf("end_of_string %b, expected %b",
                                                  dec_item.end_of_string,
                                                  want.end_of_string));
                    if (dec_item.likely_utf !== want.likely_utf)
                        report_mismatch($sformatf("likely_utf %b, expected %b",
                                                  dec_item.likely_utf, want.likely_utf));
                end
            end
            stall_pct = (idle_mode == MODE_SLOW_SINK) ? 86 :
                        (idle_mode == MODE_SLOW_SRC) ? 14 : 0;
            dec_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: ends the run when neither side moves for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((byte_valid && !byte_stall) || (dec_valid && !dec_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("pdf_string_escape_decoder test failed");
                $finish;
            end
        end
    end

    initial begin
        // Every escape letter, an unknown escape, and the byte extremes.
        add_string(160'h5c6e5c725c745c625c665c285c295c5c5c7100ff, 20, 1'b0);
        // Digits 8 or 9 in a three-digit run: nothing decoded, empty end.
        add_string(160'h5c313832, 4, 1'b0);
        // Lone trailing backslash.
        add_string(160'h5c, 1, 1'b0);
        // Digit ends the string one digit into a run.
        add_string(160'h5c3132, 3, 1'b0);
        // Digit as the last byte right after a backslash.
        add_string(160'h5c35, 2, 1'b0);
        // Full octal escape, then a run cut short by a letter.
        add_string(160'h5c3337375c313241, 8, 1'b1);
        // Just below and above the non-ASCII boundary.
        add_string(160'h7f, 1, 1'b0);
        add_string(160'h7f80, 2, 1'b0);
        add_random_strings();
        total_items = request_q.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() > 0 || byte_valid || decoded_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("pdf_string_escape_decoder test passed");
        else
            $display("pdf_string_escape_decoder test failed");
        $finish;
    end

endmodule

`default_nettype wire
